// ===== src/edit_distance_engine_unit_defines.svh =====
// Assertion macros for the edit distance engine.
`ifndef EDIT_DISTANCE_ENGINE_UNIT_DEFINES_SVH
`define EDIT_DISTANCE_ENGINE_UNIT_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define EDE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define EDE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ede_pkg.sv =====
// ----------------------------------------------------------------------------
// ede_pkg
// Shared types and codes for the edit distance engine.
// ----------------------------------------------------------------------------
`default_nettype none
package ede_pkg;

    localparam int unsigned FIELD_W = 7;

    typedef enum logic [1:0] {
        MODE_FIRST  = 2'd0,
        MODE_SECOND = 2'd1,
        MODE_FINISH = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] symbol;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_W-1:0] distance;
        logic [FIELD_W-1:0] longer_length;
        logic               truncated;
    } t_out_item;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROWSTART,
        ST_CELL,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

// ===== src/ede_ram.sv =====
// ----------------------------------------------------------------------------
// ede_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module ede_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== src/ede_front.sv =====
// ----------------------------------------------------------------------------
// ede_front
// Accepts input transactions, drops unused modes and forwards the rest
// into a two-entry queue toward the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module ede_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire ede_pkg::t_in_item i_in_data,
    output logic                   o_in_stall,
    output logic                   o_q_valid,
    output ede_pkg::t_in_item      o_q_data,
    input  wire logic              i_q_pop
);
    import ede_pkg::*;

    t_in_item r_ent [2];
    logic     r_wp, r_rp;
    logic [1:0] r_cnt;
    logic     push;

    assign o_in_stall = (r_cnt == 2'd2);
    // Unused mode is accepted and discarded
    assign push = i_in_valid && !o_in_stall && (i_in_data.mode != MODE_NONE);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_data  = r_ent[r_rp];

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ent[r_wp] <= i_in_data;
        end
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end
endmodule
`default_nettype wire

// ===== src/ede_back.sv =====
// ----------------------------------------------------------------------------
// ede_back
// Stores string bytes and runs the cost-row recurrence one cell per cycle
// on a finish, then holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none
module ede_back #(
    parameter int unsigned MAX_LEN = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_valid,
    input  wire ede_pkg::t_in_item  i_q_data,
    output logic                    o_q_pop,
    output logic                    o_out_valid,
    output ede_pkg::t_out_item      o_out_data,
    input  wire logic               i_out_stall,
    output logic                    o_busy
);
    import ede_pkg::*;

    localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int unsigned LW = $clog2(MAX_LEN + 1);
    localparam int unsigned CW = $clog2(MAX_LEN + 1);
    localparam int unsigned VW = (LW > 1) ? LW : 1;

    t_state r_state, n_state;
    logic [LW-1:0] r_len_a, r_len_b;
    logic          r_ovf;
    logic [LW-1:0] r_i, r_j;
    logic [VW-1:0] r_diag, r_left;
    logic          r_out_valid;
    t_out_item     r_out;
    logic [VW-1:0] cost_rd;
    logic [7:0]    a_rd, b_rd;
    logic          cost_we;
    logic [CW-1:0] cost_wa, cost_ra;
    logic [VW-1:0] cost_wd;
    logic          is_load, take;
    logic [VW-1:0] up, m1, m2, cell_cost;
    logic [AW-1:0] a_wa, b_wa, a_ra, b_ra;
    logic          a_we, b_we;

    assign is_load = (i_q_data.mode == MODE_FIRST) || (i_q_data.mode == MODE_SECOND);
    // Loads run whenever idle; finish waits for a free output register
    assign take = i_q_valid && (r_state == ST_IDLE)
                  && (is_load || !r_out_valid);
    assign o_q_pop = take;
    assign o_busy  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // String writes
    assign a_we = take && (i_q_data.mode == MODE_FIRST) && (r_len_a < LW'(MAX_LEN));
    assign b_we = take && (i_q_data.mode == MODE_SECOND) && (r_len_b < LW'(MAX_LEN));
    assign a_wa = AW'(r_len_a);
    assign b_wa = AW'(r_len_b);
    // Row byte a[i-1]; column byte b[j] for the next cell
    assign a_ra = AW'(r_i - LW'(1));
    assign b_ra = AW'(r_j);

    ede_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_ram_a (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(a_wa), .i_wdata(i_q_data.symbol),
        .i_raddr(a_ra), .o_rdata(a_rd));
    ede_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_ram_b (
        .i_clk(i_clk), .i_we(b_we), .i_waddr(b_wa), .i_wdata(i_q_data.symbol),
        .i_raddr(b_ra), .o_rdata(b_rd));
    ede_ram #(.WIDTH(VW), .DEPTH(MAX_LEN + 1)) u_ram_c (
        .i_clk(i_clk), .i_we(cost_we), .i_waddr(cost_wa), .i_wdata(cost_wd),
        .i_raddr(cost_ra), .o_rdata(cost_rd));

    // Cell update: up = cost_row[j], left = cost_row[j-1] (held), diag held
    assign up        = cost_rd;
    assign m1        = (up < r_left) ? up : r_left;
    assign m2        = (m1 < r_diag) ? m1 : r_diag;
    assign cell_cost = (a_rd == b_rd) ? r_diag : (m2 + VW'(1));

    // Cost row port control
    always_comb begin
        cost_we = 1'b0;
        cost_wa = CW'(r_j);
        cost_wd = VW'(r_j);
        cost_ra = CW'(r_j);
        case (r_state)
            ST_INIT: begin
                cost_we = 1'b1;
            end
            ST_ROWSTART: begin
                // write new cost_row[0] = i, fetch cost_row[1] for the first cell
                cost_we = 1'b1;
                cost_wa = '0;
                cost_wd = VW'(r_i);
                cost_ra = CW'(1);
            end
            ST_CELL: begin
                cost_we = 1'b1;
                cost_wa = CW'(r_j);
                cost_wd = cell_cost;
                cost_ra = CW'(r_j) + CW'(1);
            end
            default: begin
                cost_ra = CW'(r_len_b);
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:     if (take && !is_load) n_state = ST_INIT;
            ST_INIT:     if (r_j == r_len_b) n_state = (r_len_a == '0) ? ST_DONE : ST_ROWSTART;
            ST_ROWSTART: n_state = (r_len_b == '0) ?
                                   ((r_i == r_len_a) ? ST_DONE : ST_ROWSTART) : ST_CELL;
            ST_CELL:     if (r_j == r_len_b) n_state = (r_i == r_len_a) ? ST_DONE : ST_ROWSTART;
            ST_DONE:     n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len_a     <= '0;
            r_len_b     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (a_we) r_len_a <= r_len_a + LW'(1);
                    if (b_we) r_len_b <= r_len_b + LW'(1);
                    if (take && is_load && !a_we && !b_we) r_ovf <= 1'b1;
                    r_i <= '0;
                    r_j <= '0;
                end
                ST_INIT: begin
                    // last value written is cost_row[n], kept for an empty first string
                    r_left <= VW'(r_j);
                    r_j <= r_j + LW'(1);
                    if (r_j == r_len_b) begin
                        r_i <= LW'(1);
                        r_j <= '0;
                    end
                end
                ST_ROWSTART: begin
                    // old cost_row[0] is i-1, new one is i
                    r_diag <= VW'(r_i - LW'(1));
                    r_left <= VW'(r_i);
                    r_j <= LW'(1);
                    if (r_len_b == '0) begin
                        r_i <= r_i + LW'(1);
                        r_j <= '0;
                    end
                end
                ST_CELL: begin
                    r_diag <= up;
                    r_left <= cell_cost;
                    r_j    <= r_j + LW'(1);
                    if (r_j == r_len_b) begin
                        r_i <= r_i + LW'(1);
                        r_j <= '0;
                    end
                end
                ST_DONE: begin
                    // r_left holds the final cost_row[n]
                    r_out_valid <= 1'b1;
                    r_out.distance <= FIELD_W'(r_left);
                    r_out.longer_length <= (r_len_a > r_len_b) ?
                                           FIELD_W'(r_len_a) : FIELD_W'(r_len_b);
                    r_out.truncated <= r_ovf;
                    r_len_a <= '0;
                    r_len_b <= '0;
                    r_ovf   <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== src/edit_distance_engine_unit.sv =====
// Levenshtein edit distance engine. Mode 0 and 1 transactions append one
// byte to the first or second string (one per cycle while the back end is
// idle and the queue has room; bytes past MAX_LEN are dropped and flagged);
// a mode 2 transaction runs the cost-row recurrence over a one-cell-per-cycle
// sequencer backed by three RAMs and emits one result. During the recurrence
// the cost-row RAM is written with one table cell each cycle.
// ----------------------------------------------------------------------------
// edit_distance_engine_unit
// Top level: front-end queue plus compute back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "edit_distance_engine_unit_defines.svh"
module edit_distance_engine_unit #(
    parameter int unsigned MAX_LEN = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire ede_pkg::t_in_item  i_in_data,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    output ede_pkg::t_out_item      o_out_data,
    input  wire logic               i_out_stall
);
    import ede_pkg::*;

    logic     q_valid, q_pop, busy;
    t_in_item q_data;

    ede_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_data(i_in_data), .o_in_stall(o_in_stall),
        .o_q_valid(q_valid), .o_q_data(q_data), .i_q_pop(q_pop));

    ede_back #(.MAX_LEN(MAX_LEN)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(q_valid), .i_q_data(q_data), .o_q_pop(q_pop),
        .o_out_valid(o_out_valid), .o_out_data(o_out_data),
        .i_out_stall(i_out_stall), .o_busy(busy));

    // Checks
    `EDE_ASSERT_IMPL(a_pop_needs_item, i_clk, i_rst_n, q_pop, q_valid, "pop from empty queue")
    `EDE_ASSERT_IMPL(a_pop_idle, i_clk, i_rst_n, q_pop, !busy, "pop while computing")
    `EDE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled result changed")
endmodule
`default_nettype wire

// ===== tb/edit_distance_engine_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// edit_distance_engine_unit_tb
// Drives byte loads and finish transactions into the edit distance engine,
// predicts each result with a row-at-a-time Levenshtein model and checks
// every result field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none
module edit_distance_engine_unit_tb;
    import ede_pkg::*;

    localparam int unsigned STR_CAP     = 64;
    localparam int          TOTAL_ITEMS = 1550;
    localparam longint      CYCLE_LIMIT = 3000000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    t_in_item  i_in_data = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;
    logic      i_out_stall = 1'b0;

    int     error_count = 0;
    longint cycle_count = 0;
    int     send_idle_pct = 24;
    int     recv_idle_pct = 51;
    bit     hold_off = 1'b0;
    bit     stim_done = 1'b0;

    edit_distance_engine_unit #(.MAX_LEN(STR_CAP)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0d expected %0d at cycle %0d",
                 what, got, want, cycle_count);
        error_count++;
    endtask

    // Scoreboard: shadow strings plus queue of predicted distances
    class distance_scoreboard;
        logic [7:0] first_str[STR_CAP];
        logic [7:0] second_str[STR_CAP];
        int         first_len;
        int         second_len;
        bit         dropped;
        t_out_item  pending_q[$];

        function new();
            first_len = 0;
            second_len = 0;
            dropped = 1'b0;
        endfunction

        function automatic int levenshtein();
            int row[STR_CAP+1];
            int diag;
            int up;
            int lo;
            for (int j = 0; j <= second_len; j++) row[j] = j;
            for (int i = 1; i <= first_len; i++) begin
                diag = row[0];
                row[0] = i;
                for (int j = 1; j <= second_len; j++) begin
                    up = row[j];
                    if (first_str[i-1] == second_str[j-1]) begin
                        row[j] = diag;
                    end else begin
                        lo = up < row[j-1] ? up : row[j-1];
                        lo = lo < diag ? lo : diag;
                        row[j] = lo + 1;
                    end
                    diag = up;
                end
            end
            return row[second_len];
        endfunction

        function void note_input(t_in_item item);
            t_out_item res;
            case (t_mode'(item.mode))
                MODE_FIRST: begin
                    if (first_len < STR_CAP) first_str[first_len++] = item.symbol;
                    else dropped = 1'b1;
                end
                MODE_SECOND: begin
                    if (second_len < STR_CAP) second_str[second_len++] = item.symbol;
                    else dropped = 1'b1;
                end
                MODE_FINISH: begin
                    res.distance = 7'(levenshtein());
                    res.longer_length = 7'(first_len > second_len ? first_len : second_len);
                    res.truncated = dropped;
                    pending_q = {pending_q, res};
                    first_len = 0;
                    second_len = 0;
                    dropped = 1'b0;
                end
                default: ;
            endcase
        endfunction

        task check_result(t_out_item got);
            t_out_item want;
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
                return;
            end
            want = pending_q.pop_front();
            if (got.distance !== want.distance)
                report_mismatch("distance", got.distance, want.distance);
            if (got.longer_length !== want.longer_length)
                report_mismatch("longer_length", got.longer_length, want.longer_length);
            if (got.truncated !== want.truncated)
                report_mismatch("truncated", got.truncated, want.truncated);
        endtask
    endclass

    distance_scoreboard sb = new();

    // Offer one transaction, hold it until accepted; valid drops only on idle
    task automatic send_item(input t_mode mode, input logic [7:0] sym);
        t_in_item item;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        item.mode = mode;
        item.symbol = sym;
        i_in_valid <= 1'b1;
        i_in_data <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(item);
    endtask

    task automatic load_string(input t_mode mode, input int len, input int alpha);
        for (int k = 0; k < len; k++)
            send_item(mode, alpha == 0 ? 8'($urandom) : 8'($urandom_range(alpha - 1)));
    endtask

    // Receiver stall and result check, sampled at the edge
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_data);
        i_out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Long receiver hold-off while the sender keeps pushing
    initial begin
        while (!(stim_done || sb.pending_q.size() > 0)) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (3000) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        int sent;
        int la;
        int lb;
        int alpha;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty pair, one side empty, extreme bytes, full and overflow
        send_item(MODE_FINISH, 8'hFF);
        send_item(MODE_FIRST, 8'h00);
        send_item(MODE_FINISH, 8'h00);
        send_item(MODE_SECOND, 8'hFF);
        send_item(MODE_NONE, 8'hA5);
        send_item(MODE_FINISH, 8'h00);
        send_item(MODE_FIRST, 8'hFF);
        send_item(MODE_SECOND, 8'hFF);
        send_item(MODE_FIRST, 8'h00);
        send_item(MODE_SECOND, 8'h55);
        send_item(MODE_FINISH, 8'h00);
        sent = 11;
        // Overflow both strings back to back with pressure on the output
        for (int p = 0; p < 4; p++) begin
            load_string(MODE_FIRST, STR_CAP + 2, 2);
            load_string(MODE_SECOND, STR_CAP + 1, 2);
            send_item(MODE_FINISH, 8'h00);
            sent += 2 * STR_CAP + 4;
        end

        // Random pairs, mostly short strings over small alphabets
        while (sent < TOTAL_ITEMS) begin
            if (sent > 900) begin
                send_idle_pct = 51;
                recv_idle_pct = 24;
            end
            if (sent > 1300) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            la = ($urandom_range(19) == 0) ? $urandom_range(STR_CAP + 3) : $urandom_range(8);
            lb = ($urandom_range(19) == 0) ? $urandom_range(STR_CAP + 3) : $urandom_range(8);
            alpha = $urandom_range(3) == 0 ? 0 : $urandom_range(4, 1);
            if ($urandom_range(9) == 0) begin
                send_item(t_mode'($urandom_range(3)), 8'($urandom));
                sent++;
            end
            load_string(MODE_FIRST, la, alpha);
            load_string(MODE_SECOND, lb, alpha);
            send_item(MODE_FINISH, 8'($urandom));
            sent += la + lb + 1;
        end
        i_in_valid <= 1'b0;
        stim_done = 1'b1;

        while (sb.pending_q.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire
